// File: rtl/e2c_pkg.sv
// e2c_pkg: shared widths, constants, lookup table and stage types for the
// epoch seconds to calendar pipeline
// no dependencies
package e2c_pkg;

  localparam int IN_W              = 38;
  localparam int IN_TDATA_W        = 40;
  localparam int OUT_TDATA_W       = 40;
  localparam int SECONDS_WIDTH_DEF = 40;
  localparam int NSTAGES           = 13;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // day split: biased seconds, 86400 = 675 * 2^7
  localparam int            U_W        = 39;
  localparam int            DAYS_W     = 22;
  localparam int            TOD_W      = 17;
  localparam int            SPD_LOG2   = 7;
  localparam int            DQ_N       = U_W - SPD_LOG2;
  localparam int            DQ_DIV     = 675;
  localparam int            DQ_SH      = 41;
  localparam logic [DQ_N-1:0] DQ_M     = DQ_N'((64'd1 << DQ_SH) / 64'(DQ_DIV));
  localparam int            DQ_REM_W   = 11;
  localparam int            DQ_RES_W   = 10;
  localparam logic [U_W-1:0] SEC_OFFSET = 39'd137439072000;

  // julian day and reform
  localparam logic [DAYS_W-1:0] DAY_BIAS   = 22'd849858;
  localparam logic [DAYS_W-1:0] REFORM_DAY = 22'd2299161;

  // alpha = (4z - 7468865) / 146097
  localparam int              NA_W       = 24;
  localparam int              ALPHA_W    = 7;
  localparam int              A_DIV      = 146097;
  localparam int              A_SH       = 41;
  localparam logic [NA_W-1:0] A_M        = NA_W'((64'd1 << A_SH) / 64'(A_DIV));
  localparam logic [NA_W-1:0] ALPHA_BIAS = 24'd7468865;

  // c = (20b - 2442) / 7305
  localparam logic [DAYS_W-1:0] B_OFS = 22'd1524;
  localparam int              NC_W    = 27;
  localparam int              C_W     = 14;
  localparam int              C_DIV   = 7305;
  localparam int              C_SH    = 39;
  localparam logic [NC_W-1:0] C_M     = NC_W'((64'd1 << C_SH) / 64'(C_DIV));
  localparam logic [NC_W-1:0] C_BIAS  = 27'd2442;
  localparam int              D_MUL   = 1461;
  localparam int              D_W     = 24;
  localparam int              BD_W    = 9;
  localparam int              E_W     = 4;
  localparam int              E_MAX   = 15;
  localparam logic [E_W-1:0]  E_WRAP  = 4'd14;
  localparam logic [E_W-1:0]  E_OFS_LO = 4'd1;
  localparam logic [E_W-1:0]  E_OFS_HI = 4'd13;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [YEAR_W-1:0] YEAR_OFS_LATE  = 14'd4716;
  localparam logic [YEAR_W-1:0] YEAR_OFS_EARLY = 14'd4715;

  // time of day: exact reciprocals over the reachable range
  localparam int MT_W  = 11;
  localparam int MT_MW = 18;
  localparam logic [MT_MW-1:0] MT_M = 18'd139811;
  localparam int MT_SH = 23;
  localparam int HR_MW = 12;
  localparam logic [HR_MW-1:0] HR_M = 12'd2185;
  localparam int HR_SH = 17;
  localparam int SIXTY = 60;

  localparam int CLK_DONE = 6;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } split_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } clock_t;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [MDAY_W-1:0]        day_of_month;
  } date_t;

  // floor(30.6001 * e)
  function automatic logic [BD_W-1:0] month_base(input logic [E_W-1:0] e);
    logic [BD_W-1:0] v;
    unique case (e)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd30;
      4'd2:  v = 9'd61;
      4'd3:  v = 9'd91;
      4'd4:  v = 9'd122;
      4'd5:  v = 9'd153;
      4'd6:  v = 9'd183;
      4'd7:  v = 9'd214;
      4'd8:  v = 9'd244;
      4'd9:  v = 9'd275;
      4'd10: v = 9'd306;
      4'd11: v = 9'd336;
      4'd12: v = 9'd367;
      4'd13: v = 9'd397;
      4'd14: v = 9'd428;
      4'd15: v = 9'd459;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/e2c_ctrl.sv
// e2c_ctrl: valid bits and per-stage load enables for the pipeline
// bubbles collapse so an empty stage takes a request while the output stalls
module e2c_ctrl #(
  parameter int NST = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [NST-1:0] en
);

  logic [NST-1:0] valid_r;
  logic [NST-1:0] valid_nxt;

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      en[k] = out_ready | ~(&(valid_r | ((NST'(1) << k) - NST'(1))));
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NST; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid_r[NST-1];

endmodule

// File: rtl/e2c_split.sv
// e2c_split: seconds wrap, bias and floor split into day count and time of day
// stages 0 to 3; uses e2c_pkg
module e2c_split #(
  parameter int SECONDS_WIDTH = e2c_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic [e2c_pkg::NSTAGES-1:0]       en,
  input  logic signed [e2c_pkg::IN_W-1:0]   in_secs,
  output e2c_pkg::split_t                   sp
);
  import e2c_pkg::*;

  logic signed [SECONDS_WIDTH-1:0] secs_r, secs_nxt;
  logic [U_W-1:0]                  u_r, u_nxt;
  logic [U_W-1:0]                  n_r;
  logic [2*DQ_N-1:0]               p_r, p_nxt;
  split_t                          sp_r, sp_nxt;

  logic [DAYS_W-1:0] q_est;
  logic [DQ_N-1:0]   rem_full;
  logic [DQ_REM_W-1:0] rem;
  logic [DQ_RES_W-1:0] rem_c;

  always_comb begin
    secs_nxt = SECONDS_WIDTH'(in_secs);
    u_nxt    = U_W'(secs_r) + SEC_OFFSET;
    p_nxt    = (2*DQ_N)'(u_r[U_W-1:SPD_LOG2]) * (2*DQ_N)'(DQ_M);

    q_est    = DAYS_W'(p_r >> DQ_SH);
    rem_full = n_r[U_W-1:SPD_LOG2] - DQ_N'(DQ_N'(q_est) * DQ_N'(DQ_DIV));
    rem      = rem_full[DQ_REM_W-1:0];
    if (rem >= DQ_REM_W'(DQ_DIV)) begin
      sp_nxt.days = q_est + DAYS_W'(1);
      rem_c       = DQ_RES_W'(rem - DQ_REM_W'(DQ_DIV));
    end else begin
      sp_nxt.days = q_est;
      rem_c       = rem[DQ_RES_W-1:0];
    end
    sp_nxt.tod = {rem_c, n_r[SPD_LOG2-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      secs_r <= secs_nxt;
    end
    if (en[1]) begin
      u_r <= u_nxt;
    end
    if (en[2]) begin
      p_r <= p_nxt;
      n_r <= u_r;
    end
    if (en[3]) begin
      sp_r <= sp_nxt;
    end
  end

  assign sp = sp_r;

endmodule

// File: rtl/e2c_clock.sv
// e2c_clock: time of day into hour, minute and second, then delay to the output stage
// stages 4 to 12; uses e2c_pkg
module e2c_clock (
  input  logic                        clk,
  input  logic [e2c_pkg::NSTAGES-1:0] en,
  input  e2c_pkg::split_t             sp,
  output e2c_pkg::clock_t             clk_out
);
  import e2c_pkg::*;

  logic [TOD_W-1:0]  tod4_r;
  logic [MT_W-1:0]   mt4_r, mt4_nxt;
  logic [MT_W-1:0]   mt5_r;
  logic [SEC_W-1:0]  sec5_r, sec5_nxt;
  logic [HOUR_W-1:0] hr5_r, hr5_nxt;
  clock_t            c6_nxt;
  clock_t            pipe_r [CLK_DONE:NSTAGES-1];

  always_comb begin
    mt4_nxt  = MT_W'(((TOD_W+MT_MW)'(sp.tod) * (TOD_W+MT_MW)'(MT_M)) >> MT_SH);
    sec5_nxt = SEC_W'(tod4_r - TOD_W'(TOD_W'(mt4_r) * TOD_W'(SIXTY)));
    hr5_nxt  = HOUR_W'(((MT_W+HR_MW)'(mt4_r) * (MT_W+HR_MW)'(HR_M)) >> HR_SH);
    c6_nxt.hour   = hr5_r;
    c6_nxt.minute = MIN_W'(mt5_r - MT_W'(MT_W'(hr5_r) * MT_W'(SIXTY)));
    c6_nxt.second = sec5_r;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tod4_r <= sp.tod;
      mt4_r  <= mt4_nxt;
    end
    if (en[5]) begin
      mt5_r  <= mt4_r;
      sec5_r <= sec5_nxt;
      hr5_r  <= hr5_nxt;
    end
    if (en[CLK_DONE]) begin
      pipe_r[CLK_DONE] <= c6_nxt;
    end
    for (int k = CLK_DONE + 1; k < NSTAGES; k++) begin
      if (en[k]) begin
        pipe_r[k] <= pipe_r[k-1];
      end
    end
  end

  assign clk_out = pipe_r[NSTAGES-1];

endmodule

// File: rtl/e2c_date.sv
// e2c_date: day count into year, month and day (julian day to calendar)
// stages 4 to 12; uses e2c_pkg
module e2c_date (
  input  logic                        clk,
  input  logic [e2c_pkg::NSTAGES-1:0] en,
  input  e2c_pkg::split_t             sp,
  output e2c_pkg::date_t              date
);
  import e2c_pkg::*;

  logic [DAYS_W-1:0]    z4_r, z4_nxt, z5_r, z6_r;
  logic                 jul4_r, jul4_nxt, jul5_r, jul6_r;
  logic [NA_W-1:0]      na4_r, na4_nxt, na5_r;
  logic [2*NA_W-1:0]    pa5_r, pa5_nxt;
  logic [ALPHA_W-1:0]   alpha6_r, alpha6_nxt, a_est;
  logic [NA_W-1:0]      a_rem;
  logic [DAYS_W-1:0]    a7, b7_r, b7_nxt, b8_r, b9_r;
  logic [NC_W-1:0]      nc7_r, nc7_nxt, nc8_r;
  logic [2*NC_W-1:0]    pc8_r, pc8_nxt;
  logic [C_W-1:0]       c_est, c9_r, c9_nxt, c10_r, c11_r;
  logic [NC_W-1:0]      c_rem;
  logic [D_W-1:0]       d10;
  logic [BD_W-1:0]      bd10_r, bd10_nxt, bd11_r;
  logic [E_MAX-1:0]     therm;
  logic [E_W-1:0]       e11_r, e11_nxt;
  logic [MONTH_W-1:0]   mon12;
  date_t                date_r, date_nxt;

  always_comb begin
    z4_nxt   = sp.days + DAY_BIAS;
    jul4_nxt = z4_nxt < REFORM_DAY;
    na4_nxt  = {z4_nxt, 2'b00} - ALPHA_BIAS;

    pa5_nxt = (2*NA_W)'(na4_r) * (2*NA_W)'(A_M);

    a_est = ALPHA_W'(pa5_r >> A_SH);
    a_rem = na5_r - NA_W'(NA_W'(a_est) * NA_W'(A_DIV));
    alpha6_nxt = (a_rem >= NA_W'(A_DIV)) ? a_est + ALPHA_W'(1) : a_est;

    if (jul6_r) begin
      a7 = z6_r;
    end else begin
      a7 = z6_r + DAYS_W'(1) + DAYS_W'(alpha6_r) - DAYS_W'(alpha6_r >> 2);
    end
    b7_nxt  = a7 + B_OFS;
    nc7_nxt = (NC_W'(b7_nxt) << 4) + (NC_W'(b7_nxt) << 2) - C_BIAS;

    pc8_nxt = (2*NC_W)'(nc7_r) * (2*NC_W)'(C_M);

    c_est  = C_W'(pc8_r >> C_SH);
    c_rem  = nc8_r - NC_W'(NC_W'(c_est) * NC_W'(C_DIV));
    c9_nxt = (c_rem >= NC_W'(C_DIV)) ? c_est + C_W'(1) : c_est;

    d10      = D_W'(D_W'(c9_r) * D_W'(D_MUL)) >> 2;
    bd10_nxt = BD_W'(b9_r - DAYS_W'(d10));

    for (int k = 1; k <= E_MAX; k++) begin
      therm[k-1] = bd10_r > month_base(E_W'(k));
    end
    e11_nxt = E_W'($countones(therm));

    mon12 = (e11_r < E_WRAP) ? e11_r - E_OFS_LO : e11_r - E_OFS_HI;
    date_nxt.month        = mon12;
    date_nxt.day_of_month = MDAY_W'(bd11_r - month_base(e11_r));
    date_nxt.year = (mon12 > FEBRUARY) ? YEAR_W'(c11_r) - YEAR_OFS_LATE
                                       : YEAR_W'(c11_r) - YEAR_OFS_EARLY;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      z4_r   <= z4_nxt;
      jul4_r <= jul4_nxt;
      na4_r  <= na4_nxt;
    end
    if (en[5]) begin
      pa5_r  <= pa5_nxt;
      na5_r  <= na4_r;
      z5_r   <= z4_r;
      jul5_r <= jul4_r;
    end
    if (en[6]) begin
      alpha6_r <= alpha6_nxt;
      z6_r     <= z5_r;
      jul6_r   <= jul5_r;
    end
    if (en[7]) begin
      b7_r  <= b7_nxt;
      nc7_r <= nc7_nxt;
    end
    if (en[8]) begin
      pc8_r <= pc8_nxt;
      nc8_r <= nc7_r;
      b8_r  <= b7_r;
    end
    if (en[9]) begin
      c9_r <= c9_nxt;
      b9_r <= b8_r;
    end
    if (en[10]) begin
      bd10_r <= bd10_nxt;
      c10_r  <= c9_r;
    end
    if (en[11]) begin
      e11_r  <= e11_nxt;
      bd11_r <= bd10_r;
      c11_r  <= c10_r;
    end
    if (en[12]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

// File: rtl/epoch_seconds_to_calendar_top.sv
// epoch_seconds_to_calendar_top: signed unix seconds to utc calendar date and time
// uses e2c_pkg, e2c_ctrl, e2c_split, e2c_clock, e2c_date
//
//   channel | tdata bits | fields, low bit first
//   --------+------------+---------------------------------------------------------
//   in_     | 40         | epoch_seconds[37:0], zero pad [39:38]
//   out_    | 40         | year[13:0] month[17:14] day_of_month[22:18] hour[27:23]
//           |            | minute[33:28] second[39:34]
//
// one request per cycle while out_tready is high or a stage is empty, 13 register stages
// the split by 86400 and the two calendar quotients are reciprocal multiplies
// each followed by a registered correction step, which sets the depth
// rst_n clears the valid bits only, no clearing pass
// a stall holds the output register; empty stages keep taking requests
module epoch_seconds_to_calendar_top #(
  parameter int SECONDS_WIDTH = e2c_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [e2c_pkg::IN_TDATA_W-1:0]     in_tdata,   // epoch_seconds
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [e2c_pkg::OUT_TDATA_W-1:0] out_tdata // year month day_of_month hour minute second
);
  import e2c_pkg::*;

  logic [NSTAGES-1:0] en;
  split_t             sp;
  clock_t             clk_res;
  date_t              date;

  e2c_ctrl #(
    .NST(NSTAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .en       (en)
  );

  e2c_split #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_split (
    .clk    (clk),
    .en     (en),
    .in_secs(in_tdata[IN_W-1:0]),
    .sp     (sp)
  );

  e2c_clock u_clock (
    .clk    (clk),
    .en     (en),
    .sp     (sp),
    .clk_out(clk_res)
  );

  e2c_date u_date (
    .clk (clk),
    .en  (en),
    .sp  (sp),
    .date(date)
  );

  assign out_tdata = {clk_res.second, clk_res.minute, clk_res.hour,
                      date.day_of_month, date.month, date.year};

endmodule

// File: rtl/e2c_chk.sv
// e2c_chk: port-level checks on the calendar pipeline, bound to the top level
// uses e2c_pkg
module e2c_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [e2c_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import e2c_pkg::*;

  logic [MONTH_W-1:0] mon;
  logic [MDAY_W-1:0]  mday;
  logic [HOUR_W-1:0]  hr;
  logic [MIN_W-1:0]   mn;
  logic [SEC_W-1:0]   sc;

  assign mon  = out_tdata[17:14];
  assign mday = out_tdata[22:18];
  assign hr   = out_tdata[27:23];
  assign mn   = out_tdata[33:28];
  assign sc   = out_tdata[39:34];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> mon >= 4'd1 && mon <= 4'd12 && mday >= 5'd1 && mday <= 5'd31)
    else $error("month or day out of range");

  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hr <= 5'd23 && mn <= 6'd59 && sc <= 6'd59)
    else $error("time of day out of range");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused with empty output");

endmodule

bind epoch_seconds_to_calendar_top e2c_chk u_chk (.*);

// File: dv/epoch_seconds_to_calendar_top_tb.sv
// testbench for epoch_seconds_to_calendar_top: streams timestamps with random gaps and
// output backpressure, predicts each calendar date and time of day on its own and compares
// depends on e2c_pkg and epoch_seconds_to_calendar_top
module epoch_seconds_to_calendar_top_tb;
  import e2c_pkg::*;

  localparam int    SECONDS_WIDTH = SECONDS_WIDTH_DEF;
  localparam longint SECS_PER_DAY = 86400;
  localparam longint EPOCH_JDN    = 2440588;
  localparam longint REFORM_JDN   = 2299161;
  localparam longint REFORM_DAYS  = REFORM_JDN - EPOCH_JDN;
  localparam longint MAX_DAYS     = 1590000;
  localparam int     CYCLE_LIMIT  = 300000;
  localparam int     DRAIN_CYCLES = 2 * NSTAGES;

  localparam int YEAR_LO  = 0;
  localparam int MONTH_LO = YEAR_LO + YEAR_W;
  localparam int MDAY_LO  = MONTH_LO + MONTH_W;
  localparam int HOUR_LO  = MDAY_LO + MDAY_W;
  localparam int MIN_LO   = HOUR_LO + HOUR_W;
  localparam int SEC_LO   = MIN_LO + MIN_W;

  typedef struct {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [MDAY_W-1:0]        day_of_month;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;
  } cal_date_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // epoch_seconds, pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // year, month, day_of_month, hour, minute, second

  int        idle_pct = 27;
  int        stall_pct = 27;
  int        err_count = 0;
  int        cycle_count = 0;
  cal_date_t expected_dates[$];

  epoch_seconds_to_calendar_top #(.SECONDS_WIDTH(SECONDS_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor split into days and time of day, then julian day number to calendar date
  function automatic cal_date_t calendar_of(input logic [IN_TDATA_W-1:0] word);
    longint secs, days, tod, z, a, b, c, d, e, alpha, mday, mon, yr;
    logic [SECONDS_WIDTH-1:0] wrapped;
    cal_date_t r;
    secs = $signed(word[IN_W-1:0]);
    wrapped = secs[SECONDS_WIDTH-1:0];
    secs = $signed(wrapped);
    days = secs / SECS_PER_DAY;
    tod = secs % SECS_PER_DAY;
    if (tod < 0) begin
      days -= 1;
      tod += SECS_PER_DAY;
    end
    z = EPOCH_JDN + days;
    if (z < REFORM_JDN) begin
      a = z;
    end else begin
      alpha = (4 * z - 7468865) / 146097;
      a = z + 1 + alpha - alpha / 4;
    end
    b = a + 1524;
    c = (20 * b - 2442) / 7305;
    d = (1461 * c) / 4;
    e = (10000 * (b - d)) / 306001;
    mday = b - d - (306001 * e) / 10000;
    mon = (e < 14) ? e - 1 : e - 13;
    yr = (mon > 2) ? c - 4716 : c - 4715;
    r.year = yr[YEAR_W-1:0];
    r.month = mon[MONTH_W-1:0];
    r.day_of_month = mday[MDAY_W-1:0];
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod / 60) % 60);
    r.second = 6'(tod % 60);
    return r;
  endfunction

  function automatic cal_date_t date_from_bus(input logic [OUT_TDATA_W-1:0] w);
    cal_date_t r;
    r.year = w[YEAR_LO +: YEAR_W];
    r.month = w[MONTH_LO +: MONTH_W];
    r.day_of_month = w[MDAY_LO +: MDAY_W];
    r.hour = w[HOUR_LO +: HOUR_W];
    r.minute = w[MIN_LO +: MIN_W];
    r.second = w[SEC_LO +: SEC_W];
    return r;
  endfunction

  function automatic longint secs_at(input longint days, input longint tod);
    return days * SECS_PER_DAY + tod;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    cal_date_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_dates.push_back(calendar_of(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          want = expected_dates.pop_front();
          got = date_from_bus(out_tdata);
          check_field("year", 16'(want.year), 16'(got.year));
          check_field("month", 16'(want.month), 16'(got.month));
          check_field("day_of_month", 16'(want.day_of_month), 16'(got.day_of_month));
          check_field("hour", 16'(want.hour), 16'(got.hour));
          check_field("minute", 16'(want.minute), 16'(got.minute));
          check_field("second", 16'(want.second), 16'(got.second));
        end
      end
    end
  end

  // one request, with random idle cycles in front of it, held until accepted
  task automatic send_request(input logic [IN_W-1:0] secs, input logic [1:0] pad);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= IN_TDATA_W'({$urandom(), $urandom()});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pad, secs};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic test_directed();
    longint vals[$] = '{
      0, -1, 1, 86399, 86400, -86400, -86401,
      64'sd137438953471, -64'sd137438953472,
      secs_at(REFORM_DAYS, 0), secs_at(REFORM_DAYS, 0) - 1,
      951782399, 951782400, 951868800,
      -64'sd2203891201, -64'sd2203891200, 2147483647, 64'sd2147483648,
      -64'sd62135596800, 64'h2A_AAAA_AAAA, 64'h15_5555_5555
    };
    foreach (vals[i])
      send_request(vals[i][IN_W-1:0], 2'b00);
    // pad bits above the seconds field are ignored
    send_request('0, 2'b11);
    send_request('1, 2'b10);
    send_request(38'd12345, 2'b01);
  endtask

  task automatic test_uniform_range(input int count);
    logic [63:0] raw;
    repeat (count) begin
      raw = {$urandom(), $urandom()};
      send_request(raw[IN_W-1:0], 2'($urandom_range(0, 3)));
    end
  endtask

  // days near the calendar reform, near 1970 and across the whole range,
  // with the time of day often on a day edge
  task automatic test_calendar_boundaries(input int count);
    longint days, tod, secs;
    repeat (count) begin
      case ($urandom_range(0, 2))
        0: days = REFORM_DAYS + $signed($urandom_range(0, 1600)) - 800;
        1: days = $signed($urandom_range(0, 80000)) - 40000;
        default: days = $signed($urandom_range(0, 2 * MAX_DAYS)) - MAX_DAYS;
      endcase
      case ($urandom_range(0, 3))
        0: tod = 0;
        1: tod = SECS_PER_DAY - 1;
        default: tod = $urandom_range(0, SECS_PER_DAY - 1);
      endcase
      secs = secs_at(days, tod);
      send_request(secs[IN_W-1:0], 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_full_throughput(input int count);
    idle_pct = 0;
    stall_pct = 0;
    test_uniform_range(count);
    idle_pct = 27;
    stall_pct = 27;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_uniform_range(480);
    test_calendar_boundaries(400);
    test_full_throughput(300);
    in_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/e2c_pkg.sv
rtl/e2c_ctrl.sv
rtl/e2c_split.sv
rtl/e2c_clock.sv
rtl/e2c_date.sv
rtl/epoch_seconds_to_calendar_top.sv
rtl/e2c_chk.sv
dv/epoch_seconds_to_calendar_top_tb.sv
